FILE: design/wrf_pkg.sv
// Shared types, constants and helpers for the window rank filter.
package wrf_pkg;

	// Default capacity of the block.
	localparam int DEF_MAX_RADIUS = 3;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Pixel and register widths.
	localparam int PIX_W     = 8;
	localparam int CFG_DW    = 13;
	localparam int CFG_AW    = 2;
	localparam int RADIUS_W  = 2;
	localparam int MODE_W    = 2;
	localparam int FWIDTH_W  = 11;
	localparam int FHEIGHT_W = 13;

	// Configuration register indexes.
	typedef enum logic [CFG_AW-1:0] {
		REG_RADIUS = 2'd0,
		REG_MODE   = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_index_t;

	// Rank selection codes; the remaining code behaves as median.
	localparam logic [MODE_W-1:0] MODE_MIN    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

	// Control that travels with each request through the rank chain.
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	// Window cells outside the active radius are filled with half full-scale
	// and half zero values in median mode, so the middle element is unchanged.
	// Layer pairs (odd, even) hold an even cell count: the whole odd layer
	// plus the corner of the even layer make exactly half of each pair.
	function automatic logic fill_high(input int row, input int col);
		int lyr;
		lyr = (row > col) ? row : col;
		return ((lyr % 2) == 1) || ((lyr > 0) && (row == lyr) && (col == lyr));
	endfunction

endpackage

FILE: design/wrf_line_store.sv
// Column store: one word per image column holding the pixels of earlier rows.
module wrf_line_store #(
	parameter int DEPTH  = 1024,
	parameter int WORD_W = 48
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [WORD_W-1:0]        wr_word,
	output logic [WORD_W-1:0]        rd_word
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;

	// Write the current column and prefetch the next one; when both are the
	// same column (one-pixel rows) the new word is passed straight through.
	always_ff @(posedge clk) begin
		if (en) begin
			mem[wr_addr] <= wr_word;
			rd_q <= (rd_addr == wr_addr) ? wr_word : mem[rd_addr];
		end
	end

	assign rd_word = rd_q;

endmodule

FILE: design/wrf_rank_cell.sv
// One bit step of the rank selection: settles one result bit, MSB first.
module wrf_rank_cell
	import wrf_pkg::*;
#(
	parameter int N_VALS  = 49,
	parameter int BIT_POS = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  ctl_t                            ctl_i,
	input  logic [N_VALS-1:0][PIX_W-1:0]    vals_i,
	input  logic [N_VALS-1:0]               cand_i,
	input  logic [$clog2(N_VALS)-1:0]       rank_i,
	input  logic [PIX_W-1:0]                res_i,
	output ctl_t                            ctl_o,
	output logic [N_VALS-1:0][PIX_W-1:0]    vals_o,
	output logic [N_VALS-1:0]               cand_o,
	output logic [$clog2(N_VALS)-1:0]       rank_o,
	output logic [PIX_W-1:0]                res_o
);

	localparam int RKW   = $clog2(N_VALS);
	localparam int CNT_W = $clog2(N_VALS + 1);

	logic [N_VALS-1:0] zero_set;
	logic [CNT_W-1:0]  zero_cnt;
	logic              go_low;
	logic [PIX_W-1:0]  res_nxt;

	// Count candidates with a zero at this bit and pick the half holding the rank.
	always_comb begin
		for (int i = 0; i < N_VALS; i++) begin
			zero_set[i] = cand_i[i] & ~vals_i[i][BIT_POS];
		end
		zero_cnt = CNT_W'($countones(zero_set));
		go_low = (CNT_W'(rank_i) < zero_cnt);
		res_nxt = res_i;
		res_nxt[BIT_POS] = ~go_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vals_o <= vals_i;
			res_o  <= res_nxt;
			if (go_low) begin
				cand_o <= zero_set;
				rank_o <= rank_i;
			end else begin
				cand_o <= cand_i & ~zero_set;
				rank_o <= rank_i - RKW'(zero_cnt);
			end
		end
	end

endmodule

FILE: design/window_rank_filter_unit.sv
// Top level of the streaming 2-D rank filter (median, erosion, dilation).
// The block takes one RGB pixel per clock in raster order while in_stall is
// low, converts it to gray and returns, for every pixel of the frame, the
// minimum, maximum or median of the square window of side 2r+1 around it,
// with positions outside the frame counted as zero. A result follows the
// request that carries the window's lower-right pixel, so r*W + r padding
// requests after the last pixel flush a frame. A column store of MAX_WIDTH
// words gives the earlier rows with one write and one read per request, and
// a chain of eight bit cells selects the rank, one result bit per cell.
// There is no clearing pass after reset. Any register write restarts the
// frame.
module window_rank_filter_unit
	import wrf_pkg::*;
#(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  red,
	input  logic [PIX_W-1:0]  green,
	input  logic [PIX_W-1:0]  blue,
	input  logic              is_padding,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  gray_out,
	output logic              frame_last
);

	localparam int S    = 2 * MAX_RADIUS + 1;
	localparam int T    = S * S;
	localparam int NL   = 2 * MAX_RADIUS;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT);
	localparam int HHW  = $clog2(MAX_HEIGHT + 1);
	localparam int RWD  = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS);
	localparam int RW   = $clog2(MAX_RADIUS + 1);
	localparam int LAGW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
	localparam int XW   = $clog2(MAX_WIDTH + MAX_RADIUS);
	localparam int YW   = $clog2(MAX_HEIGHT + MAX_RADIUS);
	localparam int RKW  = $clog2(T);

	// Configuration registers.
	logic [RADIUS_W-1:0]  radius_q;
	logic [MODE_W-1:0]    mode_q;
	logic [FWIDTH_W-1:0]  fwidth_q;
	logic [FHEIGHT_W-1:0] fheight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_W'(1);
			mode_q    <= MODE_MEDIAN;
			fwidth_q  <= FWIDTH_W'(640);
			fheight_q <= FHEIGHT_W'(480);
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_RADIUS: radius_q  <= cfg_data[RADIUS_W-1:0];
				REG_MODE:   mode_q    <= cfg_data[MODE_W-1:0];
				REG_WIDTH:  fwidth_q  <= cfg_data[FWIDTH_W-1:0];
				REG_HEIGHT: fheight_q <= cfg_data[FHEIGHT_W-1:0];
			endcase
		end
	end

	// Effective frame geometry with zero and oversize values clamped.
	logic [WW-1:0]   w_eff;
	logic [HHW-1:0]  h_eff;
	logic [RW-1:0]   r_eff;
	logic [LAGW-1:0] lag;

	always_comb begin
		if (fwidth_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(fwidth_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fwidth_q);
		end
		if (fheight_q == '0) begin
			h_eff = HHW'(1);
		end else if (int'(fheight_q) > MAX_HEIGHT) begin
			h_eff = HHW'(MAX_HEIGHT);
		end else begin
			h_eff = HHW'(fheight_q);
		end
		if (int'(radius_q) > MAX_RADIUS) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
		lag = LAGW'(LAGW'(r_eff) * LAGW'(w_eff) + LAGW'(r_eff));
	end

	// Handshake and output buffer state.
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             en;
	logic             acc;

	assign en       = ~skid_valid_q;
	assign in_stall = skid_valid_q;
	assign acc      = in_valid & ~in_stall;

	// Raster position of the next request and of the next window center.
	logic [CW-1:0]   col_q;
	logic [RWD-1:0]  row_q;
	logic [LAGW-1:0] fill_q;
	logic [CW-1:0]   cx_q;
	logic [HW-1:0]   cy_q;

	logic            in_frame;
	logic [12:0]     gray_sum;
	logic [PIX_W-1:0] gray;
	logic            col_wrap;
	logic            cx_wrap;
	logic            out_now;
	logic            last_now;
	logic [CW-1:0]   col_nx;

	always_comb begin
		in_frame = (row_q < h_eff);
		gray_sum = 13'(red) * 13'd11 + (13'(green) << 4) + 13'(blue) * 13'd5;
		gray = (!is_padding && in_frame) ? gray_sum[12:5] : '0;
		col_wrap = ((WW'(col_q) + WW'(1)) >= w_eff);
		cx_wrap = ((WW'(cx_q) + WW'(1)) >= w_eff);
		out_now = (fill_q == lag);
		last_now = out_now && (WW'(cx_q) == (w_eff - WW'(1)))
			&& (HHW'(cy_q) == (h_eff - HHW'(1)));
		if (last_now || col_wrap) begin
			col_nx = '0;
		end else begin
			col_nx = col_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (cfg_write) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (acc) begin
			col_q <= col_nx;
			if (last_now) begin
				row_q  <= '0;
				fill_q <= '0;
				cx_q   <= '0;
				cy_q   <= '0;
			end else begin
				if (col_wrap) begin
					row_q <= row_q + RWD'(1);
				end
				if (out_now) begin
					if (cx_wrap) begin
						cx_q <= '0;
						cy_q <= cy_q + HW'(1);
					end else begin
						cx_q <= cx_q + CW'(1);
					end
				end else begin
					fill_q <= fill_q + LAGW'(1);
				end
			end
		end
	end

	// Column store: lane j holds the pixel j+1 rows above in the same column.
	logic [NL*PIX_W-1:0] rd_word;
	logic [NL*PIX_W-1:0] wr_word;

	always_comb begin
		wr_word[PIX_W-1:0] = gray;
		for (int j = 1; j < NL; j++) begin
			wr_word[j*PIX_W +: PIX_W] = rd_word[(j-1)*PIX_W +: PIX_W];
		end
	end

	wrf_line_store #(
		.DEPTH  (MAX_WIDTH),
		.WORD_W (NL * PIX_W)
	) u_line_store (
		.clk     (clk),
		.en      (acc),
		.wr_addr (col_q),
		.rd_addr (col_nx),
		.wr_word (wr_word),
		.rd_word (rd_word)
	);

	// Window cells: row k is k image rows back, column m is m pixels back.
	logic [PIX_W-1:0] win_s1 [S][S];
	logic [CW-1:0]    cx_s1;
	logic [HW-1:0]    cy_s1;
	ctl_t             ctl_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			win_s1[0][0] <= gray;
			for (int k = 1; k < S; k++) begin
				win_s1[k][0] <= rd_word[(k-1)*PIX_W +: PIX_W];
			end
			for (int k = 0; k < S; k++) begin
				for (int m = 1; m < S; m++) begin
					win_s1[k][m] <= win_s1[k][m-1];
				end
			end
			cx_s1 <= cx_q;
			cy_s1 <= cy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= acc && out_now;
			ctl_s1.last  <= last_now;
		end
	end

	// Mask cells outside the frame and fill cells outside the active radius.
	logic [S-1:0]            row_ok;
	logic [S-1:0]            col_ok;
	logic [S-1:0]            in_rad;
	logic [XW-1:0]           tc;
	logic [YW-1:0]           tr;
	logic [T-1:0][PIX_W-1:0] vals_mx;
	logic [RKW-1:0]          rank_mx;

	always_comb begin
		tc = XW'(cx_s1) + XW'(r_eff);
		tr = YW'(cy_s1) + YW'(r_eff);
		for (int i = 0; i < S; i++) begin
			col_ok[i] = (tc >= XW'(i)) && ((tc - XW'(i)) < w_eff);
			row_ok[i] = (tr >= YW'(i)) && ((tr - YW'(i)) < h_eff);
			in_rad[i] = ((RW+1)'(i) <= (RW+1)'({r_eff, 1'b0}));
		end
		for (int k = 0; k < S; k++) begin
			for (int m = 0; m < S; m++) begin
				if (in_rad[k] && in_rad[m]) begin
					vals_mx[k*S+m] = (row_ok[k] && col_ok[m]) ? win_s1[k][m] : '0;
				end else begin
					case (mode_q)
						MODE_MIN: vals_mx[k*S+m] = '1;
						MODE_MAX: vals_mx[k*S+m] = '0;
						default:  vals_mx[k*S+m] = fill_high(k, m) ? '1 : '0;
					endcase
				end
			end
		end
		case (mode_q)
			MODE_MIN: rank_mx = '0;
			MODE_MAX: rank_mx = RKW'(T - 1);
			default:  rank_mx = RKW'(T / 2);
		endcase
	end

	logic [T-1:0][PIX_W-1:0] vals_s2;
	logic [RKW-1:0]          rank_s2;
	ctl_t                    ctl_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			vals_s2 <= vals_mx;
			rank_s2 <= rank_mx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Rank selection chain, one result bit per cell.
	logic [T-1:0][PIX_W-1:0] c_vals [PIX_W+1];
	logic [T-1:0]            c_cand [PIX_W+1];
	logic [RKW-1:0]          c_rank [PIX_W+1];
	logic [PIX_W-1:0]        c_res  [PIX_W+1];
	ctl_t                    c_ctl  [PIX_W+1];

	assign c_vals[0] = vals_s2;
	assign c_cand[0] = '1;
	assign c_rank[0] = rank_s2;
	assign c_res[0]  = '0;
	assign c_ctl[0]  = ctl_s2;

	for (genvar i = 0; i < PIX_W; i++) begin : g_rank
		wrf_rank_cell #(
			.N_VALS  (T),
			.BIT_POS (PIX_W - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (c_ctl[i]),
			.vals_i (c_vals[i]),
			.cand_i (c_cand[i]),
			.rank_i (c_rank[i]),
			.res_i  (c_res[i]),
			.ctl_o  (c_ctl[i+1]),
			.vals_o (c_vals[i+1]),
			.cand_o (c_cand[i+1]),
			.rank_o (c_rank[i+1]),
			.res_o  (c_res[i+1])
		);
	end

	// Output register with a skid entry behind it.
	logic [PIX_W-1:0] out_gray_q;
	logic             out_last_q;
	logic [PIX_W-1:0] skid_gray_q;
	logic             skid_last_q;
	logic             incoming;
	logic             out_take;

	assign incoming = en && c_ctl[PIX_W].valid;
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (incoming) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_gray_q <= skid_gray_q;
				out_last_q <= skid_last_q;
			end
		end else if (incoming) begin
			if (out_valid_q && !out_take) begin
				skid_gray_q <= c_res[PIX_W];
				skid_last_q <= c_ctl[PIX_W].last;
			end else begin
				out_gray_q <= c_res[PIX_W];
				out_last_q <= c_ctl[PIX_W].last;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign gray_out   = out_gray_q;
	assign frame_last = out_last_q;

`ifndef SYNTHESIS
	// The skid entry only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	// The frame's last center returns the raster counters to the frame start.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_now) |=> (col_q == '0 && row_q == '0 && fill_q == '0))
		else $error("counters did not restart after the frame's last pixel");

	// The column counter stays inside the active row width.
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < w_eff))
		else $error("column counter ran past the row width");

	// The warm-up count never passes the window lag.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= lag))
		else $error("warm-up count ran past the window lag");
`endif

endmodule
